@@ src/rdr_pkg.sv @@
// Shared types and constants for the rational divide/reduce block.
package rdr_pkg;

    localparam int MAG_BITS = 64;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_DEN = 2'd1,
        STATUS_DIV_ZERO = 2'd2
    } status_t;

    // Request and response items carried on the channels.
    typedef struct packed {
        logic               kind;
        logic signed [31:0] lhs_numerator;
        logic signed [31:0] lhs_denominator;
        logic signed [31:0] rhs_numerator;
        logic signed [31:0] rhs_denominator;
    } frac_req_t;

    typedef struct packed {
        logic signed [63:0] result_numerator;
        logic [62:0]        result_denominator;
        status_t            status;
    } frac_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_MOD_START,
        ST_MOD_RUN,
        ST_MOD_DONE,
        ST_DIVN_START,
        ST_DIVN_RUN,
        ST_DIVD_START,
        ST_DIVD_RUN,
        ST_OUT
    } state_t;

    // Controller commands to datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic div_start;
        logic div_step;
        logic [1:0] div_sel;   // 0: a mod b (euclid), 1: num / g, 2: den / g
        logic euclid_swap;
        logic store_num;
        logic store_den;
        logic out_load;
    } cmd_t;

    localparam logic [1:0] SEL_EUCLID = 2'd0;
    localparam logic [1:0] SEL_NUM    = 2'd1;
    localparam logic [1:0] SEL_DEN    = 2'd2;

    // Datapath status to controller.
    typedef struct packed {
        logic early;       // error or zero result, no reduction needed
        logic div_done;
        logic b_zero;      // euclid remainder operand is zero
    } stat_t;

endpackage

@@ src/rdr_if.sv @@
// Valid/ready channel interface carrying a generic payload.
interface rdr_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/rdr_ctrl.sv @@
// Controller state machine sequencing multiply, Euclid and final divisions.
module rdr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  rdr_pkg::stat_t  stat,
    output rdr_pkg::cmd_t   cmd
);
    rdr_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rdr_pkg::ST_IDLE:
                if (in_valid) state_next = rdr_pkg::ST_MUL;
            rdr_pkg::ST_MUL:
                state_next = stat.early ? rdr_pkg::ST_OUT : rdr_pkg::ST_MOD_START;
            rdr_pkg::ST_MOD_START:
                state_next = stat.b_zero ? rdr_pkg::ST_DIVN_START : rdr_pkg::ST_MOD_RUN;
            rdr_pkg::ST_MOD_RUN:
                if (stat.div_done) state_next = rdr_pkg::ST_MOD_DONE;
            rdr_pkg::ST_MOD_DONE:
                state_next = rdr_pkg::ST_MOD_START;
            rdr_pkg::ST_DIVN_START:
                state_next = rdr_pkg::ST_DIVN_RUN;
            rdr_pkg::ST_DIVN_RUN:
                if (stat.div_done) state_next = rdr_pkg::ST_DIVD_START;
            rdr_pkg::ST_DIVD_START:
                state_next = rdr_pkg::ST_DIVD_RUN;
            rdr_pkg::ST_DIVD_RUN:
                if (stat.div_done) state_next = rdr_pkg::ST_OUT;
            rdr_pkg::ST_OUT:
                if (out_ready) state_next = rdr_pkg::ST_IDLE;
            default:
                state_next = rdr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            rdr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            rdr_pkg::ST_MUL:
                cmd.mul = 1'b1;
            rdr_pkg::ST_MOD_START:
            begin
                cmd.div_sel = rdr_pkg::SEL_EUCLID;
                cmd.div_start = !stat.b_zero;
            end
            rdr_pkg::ST_MOD_RUN:
            begin
                cmd.div_sel = rdr_pkg::SEL_EUCLID;
                cmd.div_step = 1'b1;
            end
            rdr_pkg::ST_MOD_DONE:
                cmd.euclid_swap = 1'b1;
            rdr_pkg::ST_DIVN_START:
            begin
                cmd.div_sel = rdr_pkg::SEL_NUM;
                cmd.div_start = 1'b1;
            end
            rdr_pkg::ST_DIVN_RUN:
            begin
                cmd.div_sel = rdr_pkg::SEL_NUM;
                cmd.div_step = 1'b1;
                cmd.store_num = stat.div_done;
            end
            rdr_pkg::ST_DIVD_START:
            begin
                cmd.div_sel = rdr_pkg::SEL_DEN;
                cmd.div_start = 1'b1;
            end
            rdr_pkg::ST_DIVD_RUN:
            begin
                cmd.div_sel = rdr_pkg::SEL_DEN;
                cmd.div_step = 1'b1;
                cmd.store_den = stat.div_done;
                cmd.out_load = stat.div_done;
            end
            rdr_pkg::ST_OUT:
                out_valid = 1'b1;
            default:
                cmd = '0;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && in_valid) |=> state_reg == rdr_pkg::ST_MUL)
        else $error("accepted item did not start");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped under stall");
endmodule

@@ src/rdr_dp.sv @@
// Datapath: operand split, cross multiply, shared restoring divider, result regs.
module rdr_dp #(
    parameter int OPERAND_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rdr_pkg::cmd_t         cmd,
    output rdr_pkg::stat_t        stat,
    input  logic                  kind,
    input  logic signed [31:0]    lhs_numerator,
    input  logic signed [31:0]    lhs_denominator,
    input  logic signed [31:0]    rhs_numerator,
    input  logic signed [31:0]    rhs_denominator,
    output logic signed [63:0]    result_numerator,
    output logic [62:0]           result_denominator,
    output rdr_pkg::status_t      status
);
    localparam int OB = OPERAND_BITS;
    localparam int CW = $clog2(rdr_pkg::MAG_BITS + 1);

    logic [OB-1:0]    ln_reg, ld_reg, rn_reg, rd_reg;
    logic             kind_reg, neg_reg;
    rdr_pkg::status_t st_reg;
    logic [63:0]      num_reg, den_reg;   // kept values to reduce
    logic [63:0]      a_reg, b_reg;       // euclid pair, a ends as gcd
    logic [63:0]      q_reg, r_reg, dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic [63:0]      onum_reg;
    logic [62:0]      oden_reg;
    rdr_pkg::status_t ost_reg;

    function automatic logic [OB-1:0] mag(input logic [OB-1:0] v);
        return v[OB-1] ? (~v + 1'b1) : v;
    endfunction

    logic [OB-1:0]    ln_m, ld_m, rn_m, rd_m;
    rdr_pkg::status_t st_calc;
    logic             neg_calc;
    assign ln_m = mag(lhs_numerator[OB-1:0]);
    assign ld_m = mag(lhs_denominator[OB-1:0]);
    assign rn_m = mag(rhs_numerator[OB-1:0]);
    assign rd_m = mag(rhs_denominator[OB-1:0]);

    always_comb
    begin
        if (ld_m == '0 || (kind && rd_m == '0))
            st_calc = rdr_pkg::STATUS_ZERO_DEN;
        else if (kind && rn_m == '0)
            st_calc = rdr_pkg::STATUS_DIV_ZERO;
        else
            st_calc = rdr_pkg::STATUS_OK;
        if (kind)
            neg_calc = (lhs_numerator[OB-1] ^ rhs_denominator[OB-1])
                     ^ (lhs_denominator[OB-1] ^ rhs_numerator[OB-1]);
        else
            neg_calc = lhs_numerator[OB-1] ^ lhs_denominator[OB-1];
    end

    // products: one multiplier each, at most 32x32
    logic [63:0] pn, pd;
    assign pn = kind_reg ? 64'(ln_reg) * 64'(rd_reg) : 64'(ln_reg);
    assign pd = kind_reg ? 64'(ld_reg) * 64'(rn_reg) : 64'(ld_reg);

    logic [63:0] dvd_sel, dvs_sel;
    always_comb
    begin
        case (cmd.div_sel)
            rdr_pkg::SEL_NUM: begin dvd_sel = num_reg; dvs_sel = a_reg; end
            rdr_pkg::SEL_DEN: begin dvd_sel = den_reg; dvs_sel = a_reg; end
            default:          begin dvd_sel = a_reg;   dvs_sel = b_reg; end
        endcase
    end

    // one restoring step: shift in next dividend bit
    logic [64:0] r_sh, r_sub;
    assign r_sh  = {r_reg, q_reg[63]};
    assign r_sub = r_sh - {1'b0, dvs_reg};

    assign stat.early    = (st_reg != rdr_pkg::STATUS_OK) || (pn == '0);
    assign stat.div_done = (cnt_reg == CW'(1));
    assign stat.b_zero   = (b_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            cnt_reg <= CW'(rdr_pkg::MAG_BITS);
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ln_reg <= ln_m; ld_reg <= ld_m; rn_reg <= rn_m; rd_reg <= rd_m;
            kind_reg <= kind; neg_reg <= neg_calc; st_reg <= st_calc;
        end
        if (cmd.mul)
        begin
            num_reg <= pn; den_reg <= pd; a_reg <= pn; b_reg <= pd;
            onum_reg <= '0;
            oden_reg <= (st_reg == rdr_pkg::STATUS_OK) ? 63'd1 : '0;
            ost_reg  <= st_reg;
        end
        if (cmd.div_start)
        begin
            q_reg <= dvd_sel; r_reg <= '0; dvs_reg <= dvs_sel;
        end
        if (cmd.div_step)
        begin
            if (!r_sub[64])
            begin
                r_reg <= r_sub[63:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh[63:0];
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
        if (cmd.euclid_swap)
        begin
            a_reg <= b_reg; b_reg <= r_reg;
        end
        if (cmd.store_num)
        begin
            num_reg <= {q_reg[62:0], !r_sub[64]};
        end
        if (cmd.store_den)
        begin
            oden_reg <= {q_reg[61:0], !r_sub[64]};
        end
        if (cmd.out_load)
        begin
            onum_reg <= neg_reg ? (64'd0 - num_reg) : num_reg;
            ost_reg  <= rdr_pkg::STATUS_OK;
        end
    end

    assign result_numerator   = onum_reg;
    assign result_denominator = oden_reg;
    assign status             = ost_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> cnt_reg != '0)
        else $error("divider stepped past end");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> cnt_reg == CW'(rdr_pkg::MAG_BITS))
        else $error("divider count not loaded");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.euclid_swap |-> r_reg < dvs_reg)
        else $error("remainder not below divisor");
endmodule

@@ src/rational_divide_reduce.sv @@
// Top level: rational divide with gcd reduction.
// Usage:
//   req channel (sink) carries kind and two signed fractions; rsp channel
//   (source) carries the reduced numerator, denominator (positive, zero on error) and status.
//   One item is in flight at a time; req.ready is high only while idle.
//   An error or zero result goes from the multiply state straight to the
//   output state. Otherwise the products are formed, each Euclid step
//   runs the shared 64-step restoring divider, the last gcd check finds a
//   zero remainder, then two divisions by the gcd follow. The number of
//   Euclid steps is at least one and at most about 90 for the 63-bit
//   products. The block takes no new item before the result is taken;
//   on the long path the bit-serial divider dominates its time per item.
//   Reset returns the controller to idle and drops any item in progress.
//   If rsp.ready stays low the result holds and no new item is accepted.
module rational_divide_reduce #(
    parameter int OPERAND_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    rdr_if.sink   req,
    rdr_if.source rsp
);
    rdr_pkg::cmd_t  cmd;
    rdr_pkg::stat_t stat;

    rdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rdr_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .kind               (req.data.kind),
        .lhs_numerator      (req.data.lhs_numerator),
        .lhs_denominator    (req.data.lhs_denominator),
        .rhs_numerator      (req.data.rhs_numerator),
        .rhs_denominator    (req.data.rhs_denominator),
        .result_numerator   (rsp.data.result_numerator),
        .result_denominator (rsp.data.result_denominator),
        .status             (rsp.data.status)
    );
endmodule

@@ test/rational_divide_reduce_tb.sv @@
// Testbench for rational_divide_reduce: directed and random fractions checked against a predictor.
`timescale 1ns / 1ps

module rational_divide_reduce_tb;

    localparam int RANDOM_ITEMS = 1650;
    localparam int STALL_LIMIT  = 60000;

    class quotient_board;
        rdr_pkg::frac_rsp_t pending[$];
        int        mismatches = 0;
        int        checked    = 0;
        int        div_zero_seen = 0;
        int        zero_den_seen = 0;

        // sign and magnitude of a 32-bit two's complement operand
        function longint unsigned magnitude(logic [31:0] v, output bit neg);
            neg = v[31];
            return neg ? {32'd0, (~v) + 32'd1} : {32'd0, v};
        endfunction

        function longint unsigned gcd64(longint unsigned a, longint unsigned b);
            longint unsigned r;
            while (b != 0)
            begin
                r = a % b;
                a = b;
                b = r;
            end
            return a;
        endfunction

        function rdr_pkg::frac_rsp_t reduce(rdr_pkg::frac_req_t r);
            rdr_pkg::frac_rsp_t e;
            bit              ln_n, ld_n, rn_n, rd_n, neg;
            longint unsigned ln, ld, rn, rd, num, den, g;
            ln = magnitude(r.lhs_numerator, ln_n);
            ld = magnitude(r.lhs_denominator, ld_n);
            rn = magnitude(r.rhs_numerator, rn_n);
            rd = magnitude(r.rhs_denominator, rd_n);
            e.result_numerator   = '0;
            e.result_denominator = '0;
            e.status             = rdr_pkg::STATUS_OK;
            if (ld == 0 || (r.kind && rd == 0))
            begin
                e.status = rdr_pkg::STATUS_ZERO_DEN;
                return e;
            end
            if (r.kind && rn == 0)
            begin
                e.status = rdr_pkg::STATUS_DIV_ZERO;
                return e;
            end
            if (r.kind)
            begin
                num = ln * rd;
                den = ld * rn;
                neg = (ln_n != rd_n) != (ld_n != rn_n);
            end
            else
            begin
                num = ln;
                den = ld;
                neg = ln_n != ld_n;
            end
            if (num == 0)
            begin
                e.result_denominator = 63'd1;
                return e;
            end
            g = gcd64(num, den);
            if (g == 0)
                g = 1;
            num = num / g;
            den = den / g;
            e.result_numerator   = neg ? (64'd0 - num) : num;
            e.result_denominator = den[62:0];
            return e;
        endfunction

        function void note(rdr_pkg::frac_req_t r);
            rdr_pkg::frac_rsp_t e;
            e = reduce(r);
            if (e.status == rdr_pkg::STATUS_DIV_ZERO)
                div_zero_seen++;
            if (e.status == rdr_pkg::STATUS_ZERO_DEN)
                zero_den_seen++;
            pending.push_back(e);
        endfunction

        function void check(rdr_pkg::frac_rsp_t got);
            rdr_pkg::frac_rsp_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %0d/%0d status %0d",
                             got.result_numerator, got.result_denominator, got.status);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.result_numerator !== e.result_numerator ||
                got.result_denominator !== e.result_denominator ||
                got.status !== e.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: expected %0d/%0d st %0d, got %0d/%0d st %0d",
                             checked, e.result_numerator, e.result_denominator, e.status,
                             got.result_numerator, got.result_denominator, got.status);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   stall_cycles;

    rdr_if #(.T(rdr_pkg::frac_req_t)) req ();
    rdr_if #(.T(rdr_pkg::frac_rsp_t)) rsp ();

    quotient_board board = new();

    rational_divide_reduce #(.OPERAND_BITS(32)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // drain results with random backpressure
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
                board.check(rsp.data);
            rsp.ready <= rst_n && (no_idle || $urandom_range(0, 99) >= 30);
        end
    end

    // abort when nothing moves for too long
    initial
    begin
        stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog expired after %0d idle cycles", stall_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_item(rdr_pkg::frac_req_t r);
        int gap;
        if (!no_idle && $urandom_range(0, 99) < 30)
        begin
            gap = $urandom_range(1, 4);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= r;
        do
            @(posedge clk);
        while (!req.ready);
        board.note(r);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0, 1, 2: return 32'(int'($urandom_range(0, 2000)) - 1000);
            3, 4:    return 32'((int'($urandom_range(0, 60)) - 30) * int'($urandom_range(1, 720)));
            5:       return 32'd0;
            6:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 32'd1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic send_fraction(logic k, logic [31:0] ln, logic [31:0] ld,
                                 logic [31:0] rn, logic [31:0] rd);
        rdr_pkg::frac_req_t r;
        r.kind            = k;
        r.lhs_numerator   = ln;
        r.lhs_denominator = ld;
        r.rhs_numerator   = rn;
        r.rhs_denominator = rd;
        send_item(r);
    endtask

    initial
    begin
        int wait_cycles;
        rst_n     = 1'b0;
        no_idle   = 1'b0;
        req.valid = 1'b0;
        req.data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_fraction(1'b0, 32'd6, 32'd4, 32'd0, 32'd0);
        send_fraction(1'b0, 32'd0, 32'hffff_fff9, 32'd5, 32'd5);
        send_fraction(1'b0, 32'd5, 32'd0, 32'd1, 32'd1);
        send_fraction(1'b0, 32'hffff_fff6, 32'hffff_fff2, 32'hdead_beef, 32'h1234_5678);
        send_fraction(1'b0, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        send_fraction(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'd0);
        send_fraction(1'b0, 32'h8000_0000, 32'd2, 32'd0, 32'd0);
        send_fraction(1'b1, 32'd3, 32'd4, 32'd9, 32'd8);
        send_fraction(1'b1, 32'd3, 32'd0, 32'd0, 32'd8);
        send_fraction(1'b1, 32'd3, 32'd4, 32'd9, 32'd0);
        send_fraction(1'b1, 32'd3, 32'd4, 32'd0, 32'd0);
        send_fraction(1'b1, 32'd3, 32'd4, 32'd0, 32'd7);
        send_fraction(1'b1, 32'd0, 32'd4, 32'd9, 32'd7);
        send_fraction(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_fraction(1'b1, 32'h8000_0000, 32'd1, 32'd1, 32'h8000_0000);
        send_fraction(1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_fraction(1'b1, 32'hffff_ffff, 32'd1, 32'hffff_ffff, 32'hffff_ffff);
        send_fraction(1'b1, 32'hffff_fffd, 32'd5, 32'd7, 32'hffff_fff5);
        send_fraction(1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_fraction(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // hold a stretch at full rate on both sides
            no_idle = (i >= 700 && i < 1000);
            send_fraction(1'($urandom_range(0, 1)), pick_operand(), pick_operand(),
                          pick_operand(), pick_operand());
        end
        req.valid <= 1'b0;
        no_idle = 1'b0;

        wait_cycles = 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        while (wait_cycles < 20)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        $display("Checked %0d results: %0d zero-denominator, %0d divide-by-zero.",
                 board.checked, board.zero_den_seen, board.div_zero_seen);
        $display("Mismatches: %0d", board.mismatches);
        if (board.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
